FILE: src/fdt_tok_pkg.sv
package fdt_tok_pkg;

	// Structure block token codes
	localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
	localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
	localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
	localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
	localparam logic [31:0] TOK_END        = 32'h0000_0009;

	// Event kinds on the result channel
	typedef enum logic [2:0] {
		KIND_BEGIN_NODE  = 3'd0,
		KIND_END_NODE    = 3'd1,
		KIND_PROP_HEADER = 3'd2,
		KIND_NOP         = 3'd3,
		KIND_END         = 3'd4,
		KIND_NAME_WORD   = 3'd5,
		KIND_VALUE_WORD  = 3'd6,
		KIND_ERROR       = 3'd7
	} kind_t;

	// Parser phase
	typedef enum logic [2:0] {
		PH_TOKEN  = 3'd0,
		PH_NAME   = 3'd1,
		PH_LENGTH = 3'd2,
		PH_OFFSET = 3'd3,
		PH_VALUE  = 3'd4,
		PH_HALTED = 3'd5
	} phase_t;

	// Parser state carried between words
	typedef struct packed {
		phase_t      phase;
		logic [29:0] value_words_left;
		logic [31:0] saved_length;
	} parse_state_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [31:0] data;
		logic [31:0] name_offset;
		logic [31:0] value_length;
		logic        last_of_run;
	} result_t;

endpackage

FILE: src/fdt_tok_in_if.sv
interface fdt_tok_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        block_start;

	modport source (output valid, output word, output block_start, input ready);
	modport sink (input valid, input word, input block_start, output ready);
endinterface

FILE: src/fdt_tok_out_if.sv
interface fdt_tok_out_if;
	logic                valid;
	logic                ready;
	fdt_tok_pkg::kind_t  kind;
	logic [31:0]         data;
	logic [31:0]         name_offset;
	logic [31:0]         value_length;
	logic                last_of_run;

	modport source (output valid, output kind, output data, output name_offset,
		output value_length, output last_of_run, input ready);
	modport sink (input valid, input kind, input data, input name_offset,
		input value_length, input last_of_run, output ready);
endinterface

FILE: src/fdt_structure_block_tokenizer.sv
// Structure block tokenizer: one 32-bit word per cycle, sustained while the consumer keeps up.
// Path: a word passes the input register, then is decoded into the result register, where
// its event is presented on the result channel.
// Throughput: 1 word per cycle; the result register stalls the input only while a
// result waits and the consumer is not ready.
// Reset: arst_n clears valid flags and returns the parser to expecting a token.
module fdt_structure_block_tokenizer (
	input logic         clk,
	input logic         arst_n,
	fdt_tok_in_if.sink  in_ch,
	fdt_tok_out_if.source out_ch
);
	import fdt_tok_pkg::*;

	logic         valid_s1;
	logic [31:0]  word_s1;
	logic         start_s1;
	parse_state_t state_q;
	parse_state_t next_state;
	logic         emit;
	result_t      result;
	logic         valid_s2;
	result_t      result_s2;
	logic         out_free;
	logic         adv_s1;

	assign out_free    = !valid_s2 || out_ch.ready;
	assign adv_s1      = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	fdt_tok_decode u_decode (
		.state       (state_q),
		.word        (word_s1),
		.block_start (start_s1),
		.next_state  (next_state),
		.emit        (emit),
		.result      (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			word_s1  <= in_ch.word;
			start_s1 <= in_ch.block_start;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= PH_TOKEN;
			state_q.value_words_left <= '0;
			state_q.saved_length     <= '0;
		end else if (adv_s1) begin
			state_q <= next_state;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			result_s2 <= result;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.kind         = result_s2.kind;
	assign out_ch.data         = result_s2.data;
	assign out_ch.name_offset  = result_s2.name_offset;
	assign out_ch.value_length = result_s2.value_length;
	assign out_ch.last_of_run  = result_s2.last_of_run;

`ifndef SYNTHESIS
	// a value count is only pending inside a property value
	a_left_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.value_words_left != 30'd0) |-> (state_q.phase == PH_VALUE))
		else $error("value word count pending outside value phase");

	// only name and value words close a run
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.last_of_run) |->
		(result_s2.kind == KIND_NAME_WORD || result_s2.kind == KIND_VALUE_WORD))
		else $error("last_of_run on a non-run result");

	// an empty result register never holds back the input
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ch.ready)
		else $error("input stalled with free result register");

	// a halted parser produces nothing without a block start
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !start_s1 && state_q.phase == PH_HALTED) |=> !valid_s2)
		else $error("result produced while halted");
`endif

endmodule

FILE: src/fdt_tok_decode.sv
module fdt_tok_decode (
	input  fdt_tok_pkg::parse_state_t state,
	input  logic [31:0]               word,
	input  logic                      block_start,
	output fdt_tok_pkg::parse_state_t next_state,
	output logic                      emit,
	output fdt_tok_pkg::result_t      result
);
	import fdt_tok_pkg::*;

	parse_state_t cur;
	logic         zero_byte;
	logic [31:0]  len_m1;

	// block_start restarts the parser on this very word
	always_comb begin
		cur = state;
		if (block_start) begin
			cur.phase            = PH_TOKEN;
			cur.value_words_left = '0;
			cur.saved_length     = '0;
		end
	end

	assign zero_byte = (word[31:24] == 8'h00) || (word[23:16] == 8'h00) ||
		(word[15:8] == 8'h00) || (word[7:0] == 8'h00);
	// words still due after the first one: (len - 1) / 4
	assign len_m1 = cur.saved_length - 32'd1;

	// Phase step and result selection
	always_comb begin
		next_state = cur;
		emit       = 1'b0;
		result     = '0;
		unique case (cur.phase)
			PH_TOKEN: begin
				emit = 1'b1;
				priority if (word == TOK_BEGIN_NODE) begin
					next_state.phase = PH_NAME;
					result.kind      = KIND_BEGIN_NODE;
				end else if (word == TOK_END_NODE) begin
					result.kind = KIND_END_NODE;
				end else if (word == TOK_PROP) begin
					next_state.phase = PH_LENGTH;
					emit             = 1'b0;
				end else if (word == TOK_NOP) begin
					result.kind = KIND_NOP;
				end else if (word == TOK_END) begin
					result.kind = KIND_END;
				end else begin
					next_state.phase = PH_HALTED;
					result.kind      = KIND_ERROR;
					result.data      = word;
				end
			end
			PH_NAME: begin
				emit               = 1'b1;
				result.kind        = KIND_NAME_WORD;
				result.data        = word;
				result.last_of_run = zero_byte;
				if (zero_byte) begin
					next_state.phase = PH_TOKEN;
				end
			end
			PH_LENGTH: begin
				next_state.saved_length = word;
				next_state.phase        = PH_OFFSET;
			end
			PH_OFFSET: begin
				emit                = 1'b1;
				result.kind         = KIND_PROP_HEADER;
				result.name_offset  = word;
				result.value_length = cur.saved_length;
				if (cur.saved_length == 32'd0) begin
					next_state.phase            = PH_TOKEN;
					next_state.value_words_left = '0;
				end else begin
					next_state.phase            = PH_VALUE;
					next_state.value_words_left = len_m1[31:2];
				end
			end
			PH_VALUE: begin
				emit        = 1'b1;
				result.kind = KIND_VALUE_WORD;
				result.data = word;
				if (cur.value_words_left == 30'd0) begin
					next_state.phase   = PH_TOKEN;
					result.last_of_run = 1'b1;
				end else begin
					next_state.value_words_left = cur.value_words_left - 30'd1;
				end
			end
			default: begin
				// halted: words are dropped until the next block start
				next_state.phase = PH_HALTED;
			end
		endcase
	end

endmodule
